FILE: hw/rtl/mtfrt_pkg.sv
// Package for the move-to-front rank table: transfer payload types,
// command codes, field widths and parameter defaults.
// No dependencies.
package mtfrt_pkg;

  localparam int VALUE_W        = 6;
  localparam int POS_W          = 17;
  localparam int NUM_VALUES_DEF = 64;
  localparam int DECK_MAX_DEF   = 65536;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] card_value;
  } mtfrt_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } mtfrt_out_t;

endpackage

FILE: hw/rtl/mtfrt_table.sv
// Rank table: presence bits, recorded positions of each value and the card count,
// with the registered load and move-to-front update.
// Depends on mtfrt_pkg.
module mtfrt_table
  import mtfrt_pkg::*;
#(
  parameter int NUM_VALUES = NUM_VALUES_DEF,
  parameter int DECK_MAX   = DECK_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  mtfrt_in_t  item,
  output mtfrt_out_t result
);

  localparam int IW = $clog2(NUM_VALUES);
  localparam int PW = $clog2(DECK_MAX);
  localparam int CW = $clog2(DECK_MAX + 1);

  logic [NUM_VALUES-1:0] present_r, present_nxt;
  logic [PW-1:0]         fp_r   [NUM_VALUES];
  logic [PW-1:0]         fp_nxt [NUM_VALUES];
  logic [CW-1:0]         count_r, count_nxt;

  logic          is_query;
  logic          in_range;
  logic [IW-1:0] idx;
  logic          hit;
  logic          full;
  logic [PW-1:0] pos;
  logic [PW:0]   pos_inc;

  always_comb begin
    is_query = (item.command == CMD_QUERY);
    in_range = (32'(item.card_value) < 32'(NUM_VALUES));
    idx      = IW'(item.card_value);
    hit      = in_range && present_r[idx];
    full     = (32'(count_r) >= 32'(DECK_MAX));
    pos      = fp_r[idx];
    pos_inc  = {1'b0, pos} + 1'b1;

    result.found    = hit;
    result.position = hit ? POS_W'(pos_inc) : '0;
  end

  always_comb begin
    present_nxt = present_r;
    count_nxt   = count_r;
    for (int i = 0; i < NUM_VALUES; i++) begin
      fp_nxt[i] = fp_r[i];
    end
    if (go) begin
      if (!is_query) begin
        if (!full) begin
          if (in_range && !present_r[idx]) begin
            present_nxt[idx] = 1'b1;
            fp_nxt[idx]      = PW'(count_r);
          end
          count_nxt = count_r + 1'b1;
        end
      end else if (hit) begin
        for (int i = 0; i < NUM_VALUES; i++) begin
          if (present_r[i] && (fp_r[i] < pos)) begin
            fp_nxt[i] = fp_r[i] + 1'b1;
          end
        end
        fp_nxt[idx] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      count_r   <= '0;
    end else begin
      present_r <= present_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_VALUES; i++) begin
      fp_r[i] <= fp_nxt[i];
    end
  end

  // The card count never passes the deck limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DECK_MAX))
    else $error("card count beyond deck limit");

  // A load into a full deck changes neither the count nor the presence bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    go && !is_query && full |=> $stable(count_r) && $stable(present_r))
    else $error("load into full deck altered state");

  // A successful query leaves the queried value at the top of the deck.
  assert property (@(posedge clk) disable iff (!rst_n)
    go && is_query && hit |=> present_r[$past(idx)] && (fp_r[$past(idx)] == '0))
    else $error("queried value not moved to top");

  // A query never alters the card count or the presence bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    go && is_query |=> $stable(count_r) && $stable(present_r))
    else $error("query altered count or presence");

endmodule

FILE: hw/rtl/move_to_front_rank_table_unit.sv
// Top level of the move-to-front rank table: input register, rank table and
// result register. Depends on mtfrt_pkg and mtfrt_table.
//
// Usage: items arrive on the in_ channel (in_valid, in_stall, in_data) and a
// transfer takes place on each rising edge with in_valid high and in_stall low.
// A load command appends one card to the bottom of a non-full deck and produces no
// result. A query command returns, on the out_ channel, the 1-based position
// of the topmost card of the value together with a found flag, and moves that
// card to the top of the deck; an absent value gives position zero.
// A query passes from the input register through the rank table into the result
// register, and waits in the input register while the result register is not free.
// Throughput: one item per cycle unless a query is held back; the flat register array
// of recorded positions between the two registers updates as each item leaves the first.
// Reset clears the presence bits, the card count and both pipeline valid flags;
// no clearing pass is needed, so items are taken from the first cycle after it.
// While out_stall holds a waiting result, loads still proceed; a query waits in
// the input register and in_stall rises until the result register is free.
module move_to_front_rank_table_unit
  import mtfrt_pkg::*;
#(
  parameter int NUM_VALUES = NUM_VALUES_DEF,
  parameter int DECK_MAX   = DECK_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  mtfrt_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output mtfrt_out_t out_data
);

  logic       s1_valid_r, s1_valid_nxt;
  mtfrt_in_t  s1_item_r, s1_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  mtfrt_out_t out_data_r, out_data_nxt;

  logic       s1_is_query;
  logic       out_free;
  logic       s1_go;
  logic       in_take;
  mtfrt_out_t table_result;

  mtfrt_table #(
    .NUM_VALUES(NUM_VALUES),
    .DECK_MAX  (DECK_MAX)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (s1_item_r),
    .result(table_result)
  );

  always_comb begin
    s1_is_query = (s1_item_r.command == CMD_QUERY);
    out_free    = !out_valid_r || !out_stall;
    s1_go       = s1_valid_r && (!s1_is_query || out_free);
    in_stall    = s1_valid_r && !s1_go;
    in_take     = in_valid && !in_stall;

    s1_valid_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    s1_item_nxt  = in_take ? in_data : s1_item_r;

    if (s1_go && s1_is_query) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = table_result;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result that reports a missing value carries position zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.position == '0)
    else $error("not-found result with non-zero position");

  // A query held back by the result register stays in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_go |=> s1_valid_r && $stable(s1_item_r))
    else $error("held query lost from input register");

  // A waiting result is never overwritten by a new query.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(s1_go && s1_is_query))
    else $error("query processed while result register blocked");

endmodule

FILE: bench/move_to_front_rank_table_unit_tb.sv
// Self-checking testbench for move_to_front_rank_table_unit: a scoreboard class
// predicts each query result from the accepted items and checks every transfer.
// Depends on mtfrt_pkg and the RTL of the block.
`timescale 1ns / 1ps

module move_to_front_rank_table_unit_tb
  import mtfrt_pkg::*;
;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_LEN    = 300;
  localparam int SPARE_VALUE = NUM_VALUES_DEF - 1;

  class rank_table_scoreboard;
    int unsigned first_pos [NUM_VALUES_DEF];
    bit          present [NUM_VALUES_DEF];
    int unsigned cards_loaded;
    mtfrt_out_t  expected_q [$];
    int          errors;

    function new();
      cards_loaded = 0;
      errors       = 0;
      foreach (present[i]) begin
        present[i]   = 1'b0;
        first_pos[i] = 0;
      end
    endfunction

    function void note_input(mtfrt_in_t item);
      mtfrt_out_t  res;
      int unsigned v;
      int unsigned pos;
      v = item.card_value;
      if (item.command == CMD_LOAD) begin
        if (cards_loaded >= DECK_MAX_DEF) return;
        if (v < NUM_VALUES_DEF && !present[v]) begin
          present[v]   = 1'b1;
          first_pos[v] = cards_loaded;
        end
        cards_loaded++;
        return;
      end
      if (v >= NUM_VALUES_DEF || !present[v]) begin
        res.position = '0;
        res.found    = 1'b0;
        expected_q   = {expected_q, res};
        return;
      end
      pos          = first_pos[v];
      res.position = POS_W'(pos + 1);
      res.found    = 1'b1;
      for (int i = 0; i < NUM_VALUES_DEF; i++) begin
        if (present[i] && i != v && first_pos[i] < pos) first_pos[i]++;
      end
      first_pos[v] = 0;
      expected_q   = {expected_q, res};
    endfunction

    function void check_result(mtfrt_out_t got);
      mtfrt_out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual position=%0d found=%0d",
                 $time, got.position, got.found);
        return;
      end
      want = expected_q.pop_front();
      if (got.position !== want.position) begin
        errors++;
        $display("%0t: position mismatch, expected %0d, actual %0d",
                 $time, want.position, got.position);
      end
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found mismatch, expected %0d, actual %0d",
                 $time, want.found, got.found);
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  mtfrt_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  mtfrt_out_t out_data;

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req    = 1'b0;
  bit  hold_taken  = 1'b0;
  int  hold_left   = 0;
  int  cycle_count = 0;

  rank_table_scoreboard sb = new();

  move_to_front_rank_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The long hold-off is counted here, so the sender keeps offering items.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_LEN - 1;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_item(input logic cmd, input int val);
    mtfrt_in_t item;
    item.command    = cmd;
    item.card_value = VALUE_W'(val);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic run_random(input int count);
    int r;
    int v;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        send_item(CMD_LOAD, $urandom_range(0, SPARE_VALUE - 1));
      end else if (r < 90) begin
        v = $urandom_range(0, SPARE_VALUE - 1);
        for (int t = 0; t < 64 && !sb.present[v]; t++) v = $urandom_range(0, SPARE_VALUE - 1);
        send_item(CMD_QUERY, v);
      end else begin
        send_item(CMD_QUERY, $urandom_range(0, NUM_VALUES_DEF - 1));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 15;
    rx_idle_pct <= 70;
    send_item(CMD_QUERY, 0);
    send_item(CMD_QUERY, SPARE_VALUE);
    send_item(CMD_LOAD, 1);
    send_item(CMD_LOAD, 62);
    send_item(CMD_LOAD, 0);
    send_item(CMD_LOAD, 1);
    send_item(CMD_QUERY, 62);
    send_item(CMD_QUERY, 1);
    send_item(CMD_QUERY, 0);
    send_item(CMD_QUERY, 0);
    send_item(CMD_QUERY, 33);
    send_item(CMD_LOAD, 33);
    send_item(CMD_QUERY, 33);
    send_item(CMD_LOAD, 42);
    send_item(CMD_LOAD, 21);
    send_item(CMD_QUERY, 21);
    send_item(CMD_QUERY, 42);
    send_item(CMD_QUERY, 62);

    run_random(650);

    tx_idle_pct = 70;
    rx_idle_pct <= 15;
    run_random(650);

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    run_random(650);
    drain();

    // Fill the deck so that the last card sits at the bottom position.
    while (sb.cards_loaded < DECK_MAX_DEF - 1) send_item(CMD_LOAD, 0);
    send_item(CMD_LOAD, SPARE_VALUE);
    send_item(CMD_LOAD, SPARE_VALUE);
    send_item(CMD_LOAD, 5);
    rx_idle_pct <= 30;
    send_item(CMD_QUERY, SPARE_VALUE);
    send_item(CMD_QUERY, SPARE_VALUE);
    send_item(CMD_QUERY, 0);
    send_item(CMD_LOAD, 17);
    send_item(CMD_QUERY, 17);
    run_random(20);
    drain();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
